// ===== hw/rtl/obstacle_avoid_drive_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Obstacle avoid drive controller: assertion macros
// Wraps concurrent assertions so that they can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_AVOID_DRIVE_CONTROLLER_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is applied.
`define OADC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define OADC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OADC_ASSERT(lbl, prop, msg)
`define OADC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/oadc_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoid drive controller package
// Beat types, register indexes, reset values and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package oadc_pkg;

	// Field widths
	localparam int DIST_W     = 7;
	localparam int AVG_W      = 12;
	localparam int SAMPLE_W   = 16;
	localparam int TURN_W     = 16;
	localparam int SCALE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int AVG_MAX    = 4095;

	// Item commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_TIME     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_DISTANCE  = 3'd5;

	// Register reset values
	localparam logic [DIST_W-1:0]  RST_STOP_DISTANCE = 7'd10;
	localparam logic [TURN_W-1:0]  RST_TURN_TIME     = 16'd2000;
	localparam logic [SCALE_W-1:0] RST_RANGE_SCALE   = 16'd24000;
	localparam logic [DIST_W-1:0]  RST_CLAMP_LOW     = 7'd5;
	localparam logic [DIST_W-1:0]  RST_CLAMP_HIGH    = 7'd80;
	localparam logic [DIST_W-1:0]  RST_FAR_DISTANCE  = 7'd100;

	typedef struct packed {
		logic                command;
		logic [SAMPLE_W-1:0] sample_word;
	} oadc_item_t;

	typedef struct packed {
		logic              left_drive;
		logic              right_drive;
		logic              turning;
		logic              distance_valid;
		logic [DIST_W-1:0] distance;
		logic [AVG_W-1:0]  average;
	} oadc_result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} oadc_div_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_AVG,
		ST_DIV_DIST,
		ST_EMIT
	} oadc_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oadc_sdiv.sv =====
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Produces one quotient bit per cycle while busy; a DW-bit quotient per division.
// ----------------------------------------------------------------------------
`default_nettype none

module oadc_sdiv import oadc_pkg::*; #(
	parameter int DW = 16,
	parameter int VW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic      [DW-1:0] quotient,
	output oadc_div_stat_t     stat
);

	localparam int CNT_W = $clog2(DW);

	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic [VW:0]      diff;
	logic             fits;

	// One restoring step: bring down the next dividend bit and try the divisor.
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/obstacle_avoid_drive_controller.sv =====
// A tick, or a sample that does not close a block, passes through the emit state into the output register.
// A sample that closes a block runs the bit-serial divider twice (average, then
// distance), each division W bits wide with W = max(16, sum width); when the average
// is zero the second division is skipped.
// One item is in work at a time; the next is taken once the result sits in the output register.
// Reset clears the sample block, the turn and the registers to their defaults at once.
// ----------------------------------------------------------------------------
// Obstacle avoid drive controller
// Averages ADC samples, converts the average to a distance and times a turn
// away from close obstacles.
// ----------------------------------------------------------------------------
`default_nettype none

`include "obstacle_avoid_drive_controller_assert.svh"

module obstacle_avoid_drive_controller import oadc_pkg::*; #(
	parameter int SAMPLES = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire oadc_item_t            item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output oadc_result_t               result
);

	localparam int SUM_W = $clog2(SAMPLES * AVG_MAX + 1);
	localparam int CNT_W = $clog2(SAMPLES + 1);
	localparam int DW    = (SUM_W > SCALE_W) ? SUM_W : SCALE_W;
	localparam int VW    = (CNT_W > AVG_W) ? CNT_W : AVG_W;

	// Configuration registers
	logic [DIST_W-1:0]  stop_q;
	logic [TURN_W-1:0]  turn_time_q;
	logic [SCALE_W-1:0] scale_q;
	logic [DIST_W-1:0]  clamp_lo_q;
	logic [DIST_W-1:0]  clamp_hi_q;
	logic [DIST_W-1:0]  far_q;

	// Control state
	oadc_state_t       state_q;
	oadc_state_t       state_nx;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic              turn_q;
	logic [TURN_W-1:0] turn_rem_q;
	logic              result_valid_q;

	// Result payload
	logic              dv_q;
	logic [DIST_W-1:0] dist_q;
	logic [AVG_W-1:0]  avg_q;
	oadc_result_t      result_q;

	// Datapath
	logic [SUM_W-1:0]  sum_add;
	logic [CNT_W-1:0]  count_add;
	logic              blk_full;
	logic [TURN_W-1:0] rem_dec;
	logic [AVG_W-1:0]  avg_new;
	logic [DIST_W-1:0] dist_hi;
	logic [DIST_W-1:0] dist_clamped;
	logic [DIST_W-1:0] dist_final;
	logic              take_sample;

	// Controls
	logic              acc;
	logic              div_start;
	logic              check_done;
	logic              res_load;
	logic [DW-1:0]     div_dividend;
	logic [VW-1:0]     div_divisor;
	logic [DW-1:0]     div_quo;
	oadc_div_stat_t    div_stat;

	oadc_sdiv #(
		.DW(DW),
		.VW(VW)
	) u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Sample accumulation, turn countdown and distance conversion.
	always_comb begin
		sum_add      = sum_q + SUM_W'(item.sample_word[SAMPLE_W-1:4]);
		count_add    = count_q + CNT_W'(1);
		blk_full     = (count_add >= CNT_W'(SAMPLES));
		take_sample  = (item.command == CMD_SAMPLE) && !turn_q;
		rem_dec      = (turn_rem_q != '0) ? (turn_rem_q - TURN_W'(1)) : '0;
		avg_new      = div_quo[AVG_W-1:0];
		dist_hi      = (div_quo > DW'(clamp_hi_q)) ? clamp_hi_q : div_quo[DIST_W-1:0];
		dist_clamped = (dist_hi < clamp_lo_q) ? clamp_lo_q : dist_hi;
		dist_final   = (state_q == ST_DIV_AVG) ? far_q : dist_clamped;
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (take_sample && blk_full) begin
						state_nx = ST_DIV_AVG;
					end else begin
						state_nx = ST_EMIT;
					end
				end
			end
			ST_DIV_AVG: begin
				if (div_stat.done) begin
					state_nx = (avg_new == '0) ? ST_EMIT : ST_DIV_DIST;
				end
			end
			ST_DIV_DIST: begin
				if (div_stat.done) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		item_stall   = (state_q != ST_IDLE);
		acc          = item_valid && (state_q == ST_IDLE);
		div_start    = 1'b0;
		check_done   = 1'b0;
		res_load     = 1'b0;
		div_dividend = DW'(sum_add);
		div_divisor  = VW'(SAMPLES);
		unique case (state_q)
			ST_IDLE: begin
				div_start = acc && take_sample && blk_full;
			end
			ST_DIV_AVG: begin
				div_dividend = DW'(scale_q);
				div_divisor  = VW'(avg_new);
				div_start    = div_stat.done && (avg_new != '0);
				check_done   = div_stat.done && (avg_new == '0);
			end
			ST_DIV_DIST: begin
				check_done = div_stat.done;
			end
			ST_EMIT: begin
				res_load = !result_valid_q || !result_stall;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q      <= RST_STOP_DISTANCE;
			turn_time_q <= RST_TURN_TIME;
			scale_q     <= RST_RANGE_SCALE;
			clamp_lo_q  <= RST_CLAMP_LOW;
			clamp_hi_q  <= RST_CLAMP_HIGH;
			far_q       <= RST_FAR_DISTANCE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STOP_DISTANCE: stop_q      <= cfg_wdata[DIST_W-1:0];
				REG_TURN_TIME:     turn_time_q <= cfg_wdata[TURN_W-1:0];
				REG_RANGE_SCALE:   scale_q     <= cfg_wdata[SCALE_W-1:0];
				REG_CLAMP_LOW:     clamp_lo_q  <= cfg_wdata[DIST_W-1:0];
				REG_CLAMP_HIGH:    clamp_hi_q  <= cfg_wdata[DIST_W-1:0];
				REG_FAR_DISTANCE:  far_q       <= cfg_wdata[DIST_W-1:0];
				default:           stop_q      <= stop_q;
			endcase
		end
	end

	// Sequencer, sample block and turn state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sum_q          <= '0;
			count_q        <= '0;
			turn_q         <= 1'b0;
			turn_rem_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (acc) begin
				if (take_sample) begin
					sum_q   <= sum_add;
					count_q <= count_add;
				end else if ((item.command == CMD_TICK) && turn_q) begin
					turn_rem_q <= rem_dec;
					if (rem_dec == '0) begin
						turn_q  <= 1'b0;
						sum_q   <= '0;
						count_q <= '0;
					end
				end
			end
			if (check_done) begin
				sum_q   <= '0;
				count_q <= '0;
				if (dist_final <= stop_q) begin
					turn_q     <= 1'b1;
					turn_rem_q <= turn_time_q;
				end
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Result payload and output register.
	always_ff @(posedge clk) begin
		if (acc) begin
			dv_q   <= 1'b0;
			dist_q <= '0;
			avg_q  <= '0;
		end
		if ((state_q == ST_DIV_AVG) && div_stat.done) begin
			avg_q <= avg_new;
		end
		if (check_done) begin
			dv_q   <= 1'b1;
			dist_q <= dist_final;
		end
		if (res_load) begin
			result_q.left_drive     <= 1'b1;
			result_q.right_drive    <= !turn_q;
			result_q.turning        <= turn_q;
			result_q.distance_valid <= dv_q;
			result_q.distance       <= dist_q;
			result_q.average        <= avg_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The sample block stays empty for the whole of a turn.
	`OADC_ASSERT(a_turn_block_clear, turn_q |-> (sum_q == '0) && (count_q == '0), "samples held during a turn")
	// A countdown is only left over while a turn is in progress.
	`OADC_ASSERT(a_rem_idle_zero, !turn_q |-> (turn_rem_q == '0), "turn countdown outside a turn")
	// The divider only runs while the sequencer waits for it.
	`OADC_ASSERT(a_div_in_div_state, div_stat.busy |-> (state_q == ST_DIV_AVG) || (state_q == ST_DIV_DIST), "divider busy outside a division state")
	// A result without a completed block reports zero distance and average.
	`OADC_ASSERT(a_no_block_zero, result_valid && !result.distance_valid |-> (result.distance == '0) && (result.average == '0), "stale distance on a result beat")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Obstacle avoid drive controller testbench
// Sends sample and tick beats through the valid/stall channel with bursty
// gaps while the result side stalls on its own pattern. A behavioural copy
// of the sample averaging, distance conversion and turn timer predicts every
// result beat, and each result is compared field by field against it.
// ----------------------------------------------------------------------------

module testbench import oadc_pkg::*; ();

	localparam int BLOCK_LEN = 7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	oadc_item_t            item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	oadc_result_t          result;

	// Settings as the controller should hold them.
	logic [DIST_W-1:0]  set_stop_distance;
	logic [TURN_W-1:0]  set_turn_time;
	logic [SCALE_W-1:0] set_range_scale;
	logic [DIST_W-1:0]  set_clamp_low;
	logic [DIST_W-1:0]  set_clamp_high;
	logic [DIST_W-1:0]  set_far_distance;

	// Drive state as the controller should hold it.
	int unsigned        blk_sum;
	int unsigned        blk_count;
	logic               turn_on;
	logic [TURN_W-1:0]  turn_left;

	oadc_result_t drive_result_q[$];
	int           error_count = 0;
	int           burst_left = 0;
	int           block_level = 0;
	int           stall_span = 0;
	int           stall_mode = 0;

	obstacle_avoid_drive_controller #(
		.SAMPLES(BLOCK_LEN)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the result beat for one accepted beat and advances the state.
	function automatic oadc_result_t predict_drive_result(input oadc_item_t beat);
		oadc_result_t res;
		int unsigned  avg_v;
		int unsigned  dist_v;
		logic         dist_ok;
		avg_v = 0;
		dist_v = 0;
		dist_ok = 1'b0;
		if (beat.command == CMD_SAMPLE) begin
			if (!turn_on) begin
				blk_sum += beat.sample_word[15:4];
				blk_count++;
				if (blk_count >= BLOCK_LEN) begin
					avg_v = blk_sum / BLOCK_LEN;
					if (avg_v == 0) begin
						dist_v = set_far_distance;
					end else begin
						dist_v = set_range_scale / avg_v;
						if (dist_v > set_clamp_high)
							dist_v = set_clamp_high;
						if (dist_v < set_clamp_low)
							dist_v = set_clamp_low;
					end
					dist_ok = 1'b1;
					if (dist_v <= set_stop_distance) begin
						turn_on = 1'b1;
						turn_left = set_turn_time;
					end
					blk_sum = 0;
					blk_count = 0;
				end
			end
		end else if (turn_on) begin
			if (turn_left != 0)
				turn_left--;
			if (turn_left == 0) begin
				turn_on = 1'b0;
				blk_sum = 0;
				blk_count = 0;
			end
		end
		res.left_drive = 1'b1;
		res.right_drive = !turn_on;
		res.turning = turn_on;
		res.distance_valid = dist_ok;
		res.distance = dist_v[DIST_W-1:0];
		res.average = avg_v[AVG_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Result side: stalls in spans of changing character.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(10, 80);
			result_stall <= 1'b0;
		end else begin
			stall_span <= stall_span - 1;
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= !result_stall;
			endcase
		end
	end

	// Each accepted result beat is compared with the oldest prediction.
	always @(posedge clk) begin
		oadc_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (drive_result_q.size() == 0) begin
				report_mismatch("result beat with no prediction waiting");
			end else begin
				want = drive_result_q.pop_front();
				check_field("left_drive", result.left_drive, want.left_drive);
				check_field("right_drive", result.right_drive, want.right_drive);
				check_field("turning", result.turning, want.turning);
				check_field("distance_valid", result.distance_valid, want.distance_valid);
				check_field("distance", result.distance, want.distance);
				check_field("average", result.average, want.average);
			end
		end
	end

	// Sends one beat, opening a gap first when the current burst is used up.
	task automatic send_item(input oadc_item_t beat);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 30);
		end
		item_valid <= 1'b1;
		item <= beat;
		do @(posedge clk); while (item_stall);
		drive_result_q.push_back(predict_drive_result(beat));
		burst_left--;
	endtask

	task automatic send_repeat(input logic cmd, input logic [SAMPLE_W-1:0] word,
			input int count);
		oadc_item_t beat;
		beat.command = cmd;
		beat.sample_word = word;
		repeat (count) send_item(beat);
	endtask

	// Lets every outstanding result beat arrive so that the block is idle.
	task automatic drain;
		item_valid <= 1'b0;
		burst_left = 0;
		while (drive_result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
			REG_STOP_DISTANCE: set_stop_distance = value[DIST_W-1:0];
			REG_TURN_TIME:     set_turn_time = value[TURN_W-1:0];
			REG_RANGE_SCALE:   set_range_scale = value[SCALE_W-1:0];
			REG_CLAMP_LOW:     set_clamp_low = value[DIST_W-1:0];
			REG_CLAMP_HIGH:    set_clamp_high = value[DIST_W-1:0];
			REG_FAR_DISTANCE:  set_far_distance = value[DIST_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input int unsigned stop_v, input int unsigned turn_v,
			input int unsigned scale_v, input int unsigned low_v,
			input int unsigned high_v, input int unsigned far_v);
		write_reg(REG_STOP_DISTANCE, stop_v);
		write_reg(REG_TURN_TIME, turn_v);
		write_reg(REG_RANGE_SCALE, scale_v);
		write_reg(REG_CLAMP_LOW, low_v);
		write_reg(REG_CLAMP_HIGH, high_v);
		write_reg(REG_FAR_DISTANCE, far_v);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly whole sample blocks around a level picked per block, ticks mostly
	// while turning.
	task automatic run_traffic(input int unsigned num_items);
		oadc_item_t  beat;
		int unsigned done_cnt;
		int          lvl;
		done_cnt = 0;
		while (done_cnt < num_items) begin
			if (turn_on)
				beat.command = ($urandom_range(0, 3) != 0) ? CMD_TICK : CMD_SAMPLE;
			else
				beat.command = ($urandom_range(0, 9) == 0) ? CMD_TICK : CMD_SAMPLE;
			if (blk_count == 0) begin
				case ($urandom_range(0, 4))
					0: block_level = 0;
					1: block_level = AVG_MAX;
					2: block_level = $urandom_range(1, 300);
					default: block_level = $urandom_range(0, AVG_MAX);
				endcase
			end
			lvl = block_level + int'($urandom_range(0, 16)) - 8;
			if (lvl < 0)
				lvl = 0;
			if (lvl > AVG_MAX)
				lvl = AVG_MAX;
			if ($urandom_range(0, 7) == 0)
				beat.sample_word = SAMPLE_W'($urandom);
			else
				beat.sample_word = {AVG_W'(lvl), 4'($urandom)};
			done_cnt++;
			send_item(beat);
		end
		drain();
	endtask

	// Reset settings: a zero average gives the far distance; a tick while
	// driving changes nothing.
	task automatic test_reset_defaults;
		send_repeat(CMD_SAMPLE, 16'h000F, BLOCK_LEN);
		send_repeat(CMD_TICK, 16'hFFF0, 1);
		drain();
	endtask

	// Full-scale samples give a distance at the low clamp and start a turn; a sample during the turn
	// is ignored and the last tick ends it.
	task automatic test_turn_cycle;
		apply_config(RST_STOP_DISTANCE, 2, RST_RANGE_SCALE, RST_CLAMP_LOW,
			RST_CLAMP_HIGH, RST_FAR_DISTANCE);
		send_repeat(CMD_SAMPLE, 16'hFFFF, BLOCK_LEN);
		send_repeat(CMD_SAMPLE, 16'h0000, 1);
		send_repeat(CMD_TICK, 16'h0000, 2);
		drain();
	endtask

	// Zero turn length ends on the first tick; with crossed clamps the low clamp wins.
	task automatic test_zero_turn_time;
		apply_config(127, 0, RST_RANGE_SCALE, 100, 20, RST_FAR_DISTANCE);
		send_repeat(CMD_SAMPLE, 16'h8000, BLOCK_LEN);
		send_repeat(CMD_TICK, 16'h0000, 1);
		drain();
	endtask

	// Settings at the ends of their ranges.
	task automatic test_extreme_settings;
		// Every block turns, for a single tick.
		apply_config(127, 1, 16'hFFFF, 0, 127, 127);
		run_traffic(200);
		// Longest turn length, but no distance can reach the stop distance.
		apply_config(0, 16'hFFFF, 1, 1, 0, 1);
		run_traffic(200);
		// Zero scale and zero far distance: every block turns.
		apply_config(0, 3, 0, 0, 0, 0);
		run_traffic(200);
	endtask

	task automatic test_random_settings;
		apply_config(RST_STOP_DISTANCE, 20, RST_RANGE_SCALE, RST_CLAMP_LOW,
			RST_CLAMP_HIGH, RST_FAR_DISTANCE);
		run_traffic(260);
		repeat (4) begin
			apply_config($urandom_range(0, 127), $urandom_range(0, 40),
				$urandom_range(0, 65535), $urandom_range(0, 127),
				$urandom_range(0, 127), $urandom_range(0, 127));
			run_traffic(260);
		end
	endtask

	initial begin
		set_stop_distance = RST_STOP_DISTANCE;
		set_turn_time = RST_TURN_TIME;
		set_range_scale = RST_RANGE_SCALE;
		set_clamp_low = RST_CLAMP_LOW;
		set_clamp_high = RST_CLAMP_HIGH;
		set_far_distance = RST_FAR_DISTANCE;
		blk_sum = 0;
		blk_count = 0;
		turn_on = 1'b0;
		turn_left = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_turn_cycle();
		test_zero_turn_time();
		test_extreme_settings();
		test_random_settings();

		drain();
		repeat (40) @(posedge clk);
		if (drive_result_q.size() != 0)
			report_mismatch("predictions left without a result beat");
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Run limit.
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/oadc_pkg.sv
hw/rtl/oadc_sdiv.sv
hw/rtl/obstacle_avoid_drive_controller.sv
sim/testbench.sv
